>>> sv/hlfr_pkg.sv
// Package for the header/length frame receiver.
// Holds op codes, field widths and reset constants; no dependencies.
`default_nettype none

package hlfr_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 9;

  // request op codes
  localparam logic [OpW-1:0] OP_RX_BYTE = 2'd0;
  localparam logic [OpW-1:0] OP_READ    = 2'd1;
  localparam logic [OpW-1:0] OP_ACK     = 2'd2;

  // configuration register indexes
  localparam logic CFG_HEADER_BYTE = 1'b0;
  localparam logic CFG_MIN_LENGTH  = 1'b1;

  localparam logic [ByteW-1:0] HeaderReset    = 8'h55;
  localparam logic [ByteW-1:0] MinLengthReset = 8'd2;
  localparam logic [ByteW-1:0] LengthOnReject = 8'd2;

  typedef struct packed {
    logic           was_pending;
    logic [PosW-1:0] position;
    logic           in_frame;
    logic           length_rejected;
    logic           frame_dropped;
    logic           frame_done;
    logic           frame_pending;
  } status_t;

endpackage

`default_nettype wire

>>> sv/hlfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hlfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/header_length_frame_receiver.sv
// Top level of the header/length frame receiver: sync hunt, length check,
// ping-pong frame banks in hlfr_ram, read and acknowledge ops. Uses hlfr_pkg.
// Result is valid in the cycle after a request is accepted.
// Throughput: 1 request per cycle while results are not stalled; read_data comes
// straight from the bank RAM's registered read port, which is issued in the accept cycle.
// Reset: control state, config registers and output valid clear at once;
// bank contents are not cleared and no clearing pass is run.
`default_nettype none

module header_length_frame_receiver #(
  parameter int unsigned FRAME_DEPTH = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // op[1:0], data_byte[9:2], read_index[18:10]
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o    // read_data[7:0], frame_pending[8],
                                             // frame_done[9], frame_dropped[10],
                                             // length_rejected[11], in_frame[12],
                                             // position[21:13], was_pending[22]
);

  localparam int unsigned PosW  = hlfr_pkg::PosW;
  localparam int unsigned ByteW = hlfr_pkg::ByteW;
  localparam int unsigned RamD  = 2 * FRAME_DEPTH;
  localparam int unsigned AddrW = $clog2(RamD);
  localparam int unsigned CmpW  = PosW + 2;
  localparam logic [CmpW-1:0]  DepthC   = CmpW'(FRAME_DEPTH);
  localparam logic [AddrW-1:0] BankOffs = AddrW'(FRAME_DEPTH);

  // config
  logic [ByteW-1:0] header_q, min_len_q;

  // receiver state
  logic            header_seen_q, header_seen_d;
  logic            active_q, active_d;
  logic [PosW-1:0] wpos_q, wpos_d;
  logic [ByteW-1:0] exp_len_q, exp_len_d;
  logic            pending_q, pending_d;
  logic            dbank_q, dbank_d;

  // output stage
  logic               out_valid_q;
  hlfr_pkg::status_t  stat_q, stat_d;
  logic               use_ram_q, use_ram_d;
  logic [ByteW-1:0]   rdata_q, rdata_d;

  // RAM
  logic             ram_we, ram_re, wbank;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  logic                       in_fire;
  logic [hlfr_pkg::OpW-1:0]   op;
  logic [ByteW-1:0]           rx_byte;
  logic [PosW-1:0]            ridx;

  assign op      = s_axis_tdata_i[1:0];
  assign rx_byte = s_axis_tdata_i[9:2];
  assign ridx    = s_axis_tdata_i[18:10];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    header_seen_d = header_seen_q;
    active_d      = active_q;
    wpos_d        = wpos_q;
    exp_len_d     = exp_len_q;
    pending_d     = pending_q;
    dbank_d       = dbank_q;
    stat_d        = '0;
    use_ram_d     = 1'b0;
    rdata_d       = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wbank         = ~dbank_q;
    ram_waddr     = '0;
    ram_raddr     = '0;

    unique case (op)
      hlfr_pkg::OP_RX_BYTE: begin
        if (!active_q) begin
          if (rx_byte == header_q) begin
            if (header_seen_q) begin
              header_seen_d = 1'b0;
              active_d      = 1'b1;
              wpos_d        = PosW'(1);
            end else begin
              header_seen_d = 1'b1;
            end
          end else begin
            header_seen_d = 1'b0;
            wpos_d        = '0;
          end
        end
        if (active_d) begin
          ram_we    = in_fire && ({2'b00, wpos_d} < DepthC);
          ram_waddr = wbank ? BankOffs + AddrW'(wpos_d) : AddrW'(wpos_d);
          if (wpos_d == PosW'(2)) begin
            exp_len_d = rx_byte;
            if (rx_byte < min_len_q) begin
              exp_len_d              = hlfr_pkg::LengthOnReject;
              active_d               = 1'b0;
              stat_d.length_rejected = 1'b1;
            end
          end
          wpos_d = wpos_d + PosW'(1);
          if (active_d && (wpos_d == ({1'b0, exp_len_d} + PosW'(2)))) begin
            stat_d.frame_done = 1'b1;
            if (!pending_q) begin
              pending_d = 1'b1;
              dbank_d   = wbank;
            end else begin
              stat_d.frame_dropped = 1'b1;
            end
            active_d = 1'b0;
          end
        end
      end
      hlfr_pkg::OP_READ: begin
        if (ridx == '0) begin
          rdata_d = header_q;
        end else if ({2'b00, ridx} < DepthC) begin
          use_ram_d = 1'b1;
          ram_re    = in_fire;
          ram_raddr = dbank_q ? BankOffs + AddrW'(ridx) : AddrW'(ridx);
        end
      end
      hlfr_pkg::OP_ACK: begin
        stat_d.was_pending = pending_q;
        pending_d          = 1'b0;
      end
      default: begin
      end
    endcase

    stat_d.frame_pending = pending_d;
    stat_d.in_frame      = active_d;
    stat_d.position      = wpos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q      <= hlfr_pkg::HeaderReset;
      min_len_q     <= hlfr_pkg::MinLengthReset;
      header_seen_q <= 1'b0;
      active_q      <= 1'b0;
      wpos_q        <= '0;
      exp_len_q     <= hlfr_pkg::LengthOnReject;
      pending_q     <= 1'b0;
      dbank_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          hlfr_pkg::CFG_HEADER_BYTE: header_q  <= cfg_data_i;
          hlfr_pkg::CFG_MIN_LENGTH:  min_len_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        header_seen_q <= header_seen_d;
        active_q      <= active_d;
        wpos_q        <= wpos_d;
        exp_len_q     <= exp_len_d;
        pending_q     <= pending_d;
        dbank_q       <= dbank_d;
      end
      out_valid_q <= in_fire || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stat_q    <= stat_d;
      use_ram_q <= use_ram_d;
      rdata_q   <= rdata_d;
    end
  end

  hlfr_ram #(
    .Width (ByteW),
    .Depth (RamD)
  ) u_banks (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, stat_q.was_pending, stat_q.position, stat_q.in_frame,
                            stat_q.length_rejected, stat_q.frame_dropped,
                            stat_q.frame_done, stat_q.frame_pending,
                            (use_ram_q ? ram_rdata : rdata_q)};

  a_drop_implies_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stat_q.frame_dropped |-> stat_q.frame_done)
    else $error("dropped frame without frame done");

  a_done_excl_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(stat_q.frame_done && stat_q.length_rejected))
    else $error("frame done and length rejected together");

  a_active_no_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !header_seen_q)
    else $error("header hunt flag set inside a frame");

  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && op == hlfr_pkg::OP_ACK |=> !pending_q)
    else $error("pending flag survives acknowledge");

  a_no_write_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> wbank != dbank_q)
    else $error("write into delivered bank");

endmodule

`default_nettype wire
